### design/m3i_pkg.sv
// Shared types, widths and index tables for the 3x3 matrix inverse unit.
// No dependencies.
package m3i_pkg;

    localparam int FRAC_BITS_DEF = 16;
    localparam int ENT_W  = 32;          // one matrix entry
    localparam int N_ENT  = 9;
    localparam int PROD_W = 64;          // entry * entry
    localparam int ADJ_W  = 65;          // cofactor, signed
    localparam int DET_W  = 98;          // determinant, signed
    localparam int DMAG_W = 97;          // determinant magnitude
    localparam int STEPS  = 33;          // quotient bits produced per lane

    localparam int FRONT_LAT = 6;
    localparam int LANE_LAT  = STEPS + 2;
    localparam int MERGE_LAT = 1;
    localparam int TOTAL_LAT = FRONT_LAT + LANE_LAT + MERGE_LAT;

    localparam logic [ENT_W-1:0] SAT_POS = 32'h7FFF_FFFF;
    localparam logic [ENT_W-1:0] SAT_NEG = 32'h8000_0000;

    // Sarrus terms: first three added, last three subtracted
    localparam int DET_IDX [6][3] = '{
        '{0, 4, 8}, '{1, 5, 6}, '{2, 3, 7},
        '{2, 4, 6}, '{0, 5, 7}, '{1, 3, 8}
    };

    // adjugate entry k = m[a]*m[b] - m[c]*m[d]
    localparam int COF_IDX [9][4] = '{
        '{4, 8, 5, 7}, '{2, 7, 1, 8}, '{1, 5, 2, 4},
        '{5, 6, 3, 8}, '{0, 8, 2, 6}, '{2, 3, 0, 5},
        '{3, 7, 4, 6}, '{1, 6, 0, 7}, '{0, 4, 1, 3}
    };

    typedef struct packed {
        logic              dneg;
        logic              dzero;
        logic [DMAG_W-1:0] dmag;
    } t_det_info;

    typedef struct packed {
        logic [ENT_W-1:0] val;
        logic             sat;
    } t_lane_res;

    typedef struct packed {
        logic [N_ENT-1:0][ENT_W-1:0] r;
        logic                        saturated;
        logic                        singular;
    } t_result;

endpackage

### design/m3i_front.sv
// Front end: determinant by Sarrus and the nine adjugate cofactors, six stages.
// Depends on m3i_pkg.
module m3i_front (
    input  logic                             i_clk,
    input  logic                             i_en,
    input  logic signed [m3i_pkg::ENT_W-1:0] i_m [m3i_pkg::N_ENT],
    output m3i_pkg::t_det_info               o_info,
    output logic [m3i_pkg::ADJ_W-1:0]        o_amag [m3i_pkg::N_ENT],
    output logic [m3i_pkg::N_ENT-1:0]        o_aneg
);
    localparam int EW = m3i_pkg::ENT_W;
    localparam int PW = m3i_pkg::PROD_W;
    localparam int AW = m3i_pkg::ADJ_W;
    localparam int DW = m3i_pkg::DET_W;
    localparam int MW = m3i_pkg::DMAG_W;
    localparam int NE = m3i_pkg::N_ENT;

    logic signed [PW-1:0]   r_dp  [6];
    logic signed [EW-1:0]   r_dc  [6];
    logic signed [PW-1:0]   r_cp  [NE][2];
    logic signed [PW-1:0]   r_hc  [6];
    logic signed [PW:0]     r_lc  [6];
    logic signed [DW-1:0]   r_t   [6];
    logic signed [DW-1:0]   r_pos;
    logic signed [DW-1:0]   r_neg;
    logic signed [DW-1:0]   r_det;
    logic signed [AW-1:0]   r_adj [4][NE];   // stages 2..5
    logic signed [DW-1:0]   w_dabs;

    assign w_dabs = r_det[DW-1] ? -r_det : r_det;

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            for (int k = 0; k < 6; k++) begin
                // stage 1: first pair product
                r_dp[k] <= i_m[m3i_pkg::DET_IDX[k][0]] * i_m[m3i_pkg::DET_IDX[k][1]];
                r_dc[k] <= i_m[m3i_pkg::DET_IDX[k][2]];
                // stage 2: 64x32 split in two 32-bit partials
                r_hc[k] <= $signed(r_dp[k][PW-1:EW]) * r_dc[k];
                r_lc[k] <= $signed({1'b0, r_dp[k][EW-1:0]}) * r_dc[k];
                // stage 3: recombine
                r_t[k]  <= $signed({r_hc[k], 32'd0}) + r_lc[k];
            end
            for (int k = 0; k < NE; k++) begin
                r_cp[k][0] <= i_m[m3i_pkg::COF_IDX[k][0]] * i_m[m3i_pkg::COF_IDX[k][1]];
                r_cp[k][1] <= i_m[m3i_pkg::COF_IDX[k][2]] * i_m[m3i_pkg::COF_IDX[k][3]];
                r_adj[0][k] <= r_cp[k][0] - r_cp[k][1];
                r_adj[1][k] <= r_adj[0][k];
                r_adj[2][k] <= r_adj[1][k];
                r_adj[3][k] <= r_adj[2][k];
                o_aneg[k]   <= r_adj[3][k][AW-1];
                o_amag[k]   <= r_adj[3][k][AW-1] ? AW'(-r_adj[3][k]) : AW'(r_adj[3][k]);
            end
            // stage 4/5: sum the Sarrus terms
            r_pos <= r_t[0] + r_t[1] + r_t[2];
            r_neg <= r_t[3] + r_t[4] + r_t[5];
            r_det <= r_pos - r_neg;
            // stage 6: sign, magnitude, zero
            o_info.dneg  <= r_det[DW-1];
            o_info.dzero <= (r_det == '0);
            o_info.dmag  <= w_dabs[MW-1:0];
        end
    end

endmodule

### design/m3i_lane.sv
// One divider lane: |adj| << 2F over |det|, restoring, one quotient bit a stage,
// then sign and saturation. Depends on m3i_pkg.
module m3i_lane #(
    parameter int FRAC_BITS = m3i_pkg::FRAC_BITS_DEF
) (
    input  logic                          i_clk,
    input  logic                          i_en,
    input  logic [m3i_pkg::ADJ_W-1:0]     i_amag,
    input  logic                          i_aneg,
    input  m3i_pkg::t_det_info            i_info,
    output m3i_pkg::t_lane_res            o_res
);
    localparam int ST = m3i_pkg::STEPS;
    localparam int MW = m3i_pkg::DMAG_W;
    localparam int NW = m3i_pkg::ADJ_W + 2 * FRAC_BITS;
    localparam int RW = (NW > MW + ST) ? NW : MW + ST;

    logic [RW-1:0] r_rem [ST+1];
    logic [ST-1:0] r_q   [ST+1];
    logic [MW-1:0] r_d   [ST+1];
    logic          r_neg [ST+1];
    logic          r_big [ST+1];
    logic [NW-1:0] w_num;
    logic [ST-1:0] w_q;
    logic          w_sat;
    logic [m3i_pkg::ENT_W-1:0] w_val;

    assign w_num = NW'(i_amag) << (2 * FRAC_BITS);

    // check stage: quotient of 2^33 or more saturates either way
    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_rem[0] <= RW'(w_num);
            r_q[0]   <= '0;
            r_d[0]   <= i_info.dmag;
            r_neg[0] <= i_aneg ^ i_info.dneg;
            r_big[0] <= RW'(w_num) >= (RW'(i_info.dmag) << ST);
        end
    end

    for (genvar s = 1; s <= ST; s++) begin : g_step
        localparam int SH = ST - s;
        logic [RW:0] w_trial;
        assign w_trial = {1'b0, r_rem[s-1]} - ({1'b0, RW'(r_d[s-1])} << SH);
        always_ff @(posedge i_clk) begin
            if (i_en) begin
                r_rem[s] <= w_trial[RW] ? r_rem[s-1] : w_trial[RW-1:0];
                r_q[s]   <= r_q[s-1] | ({{(ST-1){1'b0}}, ~w_trial[RW]} << SH);
                r_d[s]   <= r_d[s-1];
                r_neg[s] <= r_neg[s-1];
                r_big[s] <= r_big[s-1];
            end
        end
    end

    assign w_q = r_q[ST];

    always_comb begin
        if (r_neg[ST]) begin
            w_sat = r_big[ST] || (w_q > {1'b0, m3i_pkg::SAT_NEG});
            w_val = w_sat ? m3i_pkg::SAT_NEG : (~w_q[m3i_pkg::ENT_W-1:0]) + 1'b1;
        end else begin
            w_sat = r_big[ST] || (w_q > {1'b0, m3i_pkg::SAT_POS});
            w_val = w_sat ? m3i_pkg::SAT_POS : w_q[m3i_pkg::ENT_W-1:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            o_res.val <= w_val;
            o_res.sat <= w_sat;
        end
    end

endmodule

### design/m3i_merge.sv
// Merge stage: gathers the nine lane results, singular case and saturation flag.
// Depends on m3i_pkg.
module m3i_merge (
    input  logic                    i_clk,
    input  logic                    i_en,
    input  m3i_pkg::t_lane_res      i_res [m3i_pkg::N_ENT],
    input  logic                    i_zero,
    output m3i_pkg::t_result        o_res
);
    logic w_any_sat;

    // any lane clamped
    always_comb begin
        w_any_sat = 1'b0;
        for (int k = 0; k < m3i_pkg::N_ENT; k++) begin
            if (i_res[k].sat) begin
                w_any_sat = 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            o_res.singular  <= i_zero;
            o_res.saturated <= !i_zero && w_any_sat;
            for (int k = 0; k < m3i_pkg::N_ENT; k++) begin
                o_res.r[k] <= i_zero ? '0 : i_res[k].val;
            end
        end
    end

endmodule

### design/matrix3_inverse_unit.sv
// Top level of the 3x3 matrix inverse unit; depends on m3i_pkg, m3i_front,
// m3i_lane and m3i_merge.
//
// Inverts one 3x3 matrix of signed fixed-point entries (FRAC_BITS fractional
// bits) per request, one request per clock while the skid buffer is free.
// The determinant (exact, Sarrus) and the nine adjugate cofactors are formed
// in a six-stage front end; nine divider lanes then each produce one inverse
// entry by restoring division, one quotient bit per stage (35 stages per
// lane: a range check, 33 quotient bits and sign/clamp), and a merge stage
// collects the entries and the flags. Quotients truncate toward zero and
// clamp to the 32-bit range, setting saturated (tuser bit 1). A zero
// determinant gives all-zero entries with singular (tuser bit 0) set. The
// whole pipeline advances together; an output register plus a one-entry skid
// buffer let requests keep flowing while a result waits, and s_axis_tready
// drops only once the skid buffer is in use.
module matrix3_inverse_unit #(
    parameter int FRAC_BITS = m3i_pkg::FRAC_BITS_DEF
) (
    input  logic         i_clk,
    input  logic         i_rst_n,
    input  logic         i_s_axis_tvalid,
    output logic         o_s_axis_tready,
    input  logic [287:0] i_s_axis_tdata,   // m00,m01,m02,m10,m11,m12,m20,m21,m22
    output logic         o_m_axis_tvalid,
    input  logic         i_m_axis_tready,
    output logic [287:0] o_m_axis_tdata,   // r00,r01,r02,r10,r11,r12,r20,r21,r22
    output logic [1:0]   o_m_axis_tuser    // singular, saturated
);
    localparam int NE = m3i_pkg::N_ENT;
    localparam int EW = m3i_pkg::ENT_W;
    localparam int L  = m3i_pkg::TOTAL_LAT;
    localparam int LL = m3i_pkg::LANE_LAT;

    logic signed [EW-1:0]         w_m    [NE];
    m3i_pkg::t_det_info           w_info;
    logic [m3i_pkg::ADJ_W-1:0]    w_amag [NE];
    logic [NE-1:0]                w_aneg;
    m3i_pkg::t_lane_res           w_lres [NE];
    m3i_pkg::t_result             w_res;

    logic [L-1:0]                 r_vld;
    logic [LL-1:0]                r_zero;
    logic                         r_out_vld;
    logic                         r_skid_vld;
    m3i_pkg::t_result             r_out;
    m3i_pkg::t_result             r_skid;
    logic                         w_en;
    logic                         w_out_fire;
    logic                         w_arrive;

    // pipeline moves whenever the skid buffer is free
    assign w_en            = !r_skid_vld;
    assign o_s_axis_tready = w_en;
    assign w_out_fire      = r_out_vld && i_m_axis_tready;
    assign w_arrive        = w_en && r_vld[L-1];

    for (genvar k = 0; k < NE; k++) begin : g_unpack
        assign w_m[k] = $signed(i_s_axis_tdata[EW*k +: EW]);
    end

    m3i_front u_front (
        .i_clk  (i_clk),
        .i_en   (w_en),
        .i_m    (w_m),
        .o_info (w_info),
        .o_amag (w_amag),
        .o_aneg (w_aneg)
    );

    for (genvar k = 0; k < NE; k++) begin : g_lane
        m3i_lane #(.FRAC_BITS(FRAC_BITS)) u_lane (
            .i_clk  (i_clk),
            .i_en   (w_en),
            .i_amag (w_amag[k]),
            .i_aneg (w_aneg[k]),
            .i_info (w_info),
            .o_res  (w_lres[k])
        );
    end

    // singular flag rides alongside the lanes
    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_zero <= {r_zero[LL-2:0], w_info.dzero};
        end
    end

    m3i_merge u_merge (
        .i_clk  (i_clk),
        .i_en   (w_en),
        .i_res  (w_lres),
        .i_zero (r_zero[LL-1]),
        .o_res  (w_res)
    );

    // request valid chain
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else if (w_en) begin
            r_vld <= {r_vld[L-2:0], i_s_axis_tvalid};
        end
    end

    // output register and skid buffer
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_vld  <= 1'b0;
            r_skid_vld <= 1'b0;
        end else if (r_skid_vld) begin
            if (w_out_fire) begin
                r_out_vld  <= 1'b1;
                r_skid_vld <= 1'b0;
            end
        end else if (w_arrive) begin
            if (!r_out_vld || w_out_fire) begin
                r_out_vld <= 1'b1;
            end else begin
                r_skid_vld <= 1'b1;
            end
        end else if (w_out_fire) begin
            r_out_vld <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_skid_vld) begin
            if (w_out_fire) begin
                r_out <= r_skid;
            end
        end else if (w_arrive) begin
            if (!r_out_vld || w_out_fire) begin
                r_out <= w_res;
            end else begin
                r_skid <= w_res;
            end
        end
    end

    assign o_m_axis_tvalid = r_out_vld;
    assign o_m_axis_tdata  = r_out.r;
    assign o_m_axis_tuser  = {r_out.saturated, r_out.singular};

endmodule
